// ===== hdl/array_list_table_engine_macros.svh =====
`ifndef ARRAY_LIST_TABLE_ENGINE_MACROS_SVH
`define ARRAY_LIST_TABLE_ENGINE_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ALTE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define ALTE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== hdl/alte_pkg.sv =====
package alte_pkg;
  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_GET    = 3'd3,
    OP_SET    = 3'd4,
    OP_SEARCH = 3'd5,
    OP_SORTA  = 3'd6,
    OP_SORTD  = 3'd7
  } op_e;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,
    S_WAIT  = 8'b0000_0100,
    S_STEP  = 8'b0000_1000,
    S_WR2   = 8'b0001_0000,
    S_LAST  = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_e;

  // Shared comparator request and response
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic eq;
    logic gt;
    logic lt;
  } cmp_rsp_t;
endpackage

// ===== hdl/alte_cmp.sv =====
module alte_cmp (
  input  alte_pkg::cmp_req_t req_i,
  output alte_pkg::cmp_rsp_t rsp_o
);
  import alte_pkg::*;
  always_comb begin
    rsp_o.eq = (req_i.a == req_i.b);
    rsp_o.gt = ($signed(req_i.a) > $signed(req_i.b));
    rsp_o.lt = ($signed(req_i.a) < $signed(req_i.b));
  end
endmodule

// ===== hdl/array_list_table_engine.sv =====
// Append, set and failed commands go from decode (S_RD) to S_DONE and then to the result;
// get adds a read in S_LAST. Insert, remove and search move or compare one entry per
// S_WAIT/S_STEP pair. Sort loads each pass's first entry (S_WAIT, S_WR2), compares each pair
// in S_STEP and spends S_LAST on the second write of a swap. One command is in flight at a
// time; the next transfer is accepted in the cycle after the result transfer.
// Reset (rst_ni low, asynchronous) empties the list and sets capacity to 64; memory is kept.
`include "array_list_table_engine_macros.svh"
module array_list_table_engine #(
  parameter int DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [6:0]  position_i,
  input  logic signed [31:0] value_i,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic signed [31:0] read_value_o,
  output logic [6:0]  found_position_o,
  output logic [6:0]  list_length_o,
  output logic        is_empty_o,
  output logic        is_full_o
);
  import alte_pkg::*;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 7) ? CW + 1 : 8;

  logic [31:0] mem_q [DEPTH];
  logic [31:0] rdata_q;
  logic [AW-1:0] raddr, waddr;
  logic        we;
  logic [31:0] wdata;

  state_e      st_q, st_d;
  op_e         op_q;
  logic [6:0]  pos_q;
  logic [31:0] val_q, hold_q, hold_d;
  logic [CW-1:0] cnt_q, cnt_d, k_q, k_d, lim_q, lim_d;
  logic [6:0]  cap_q;
  logic        ok_q, ok_d, swp_q, swp_d;
  logic [31:0] rv_q, rv_d;
  logic [6:0]  fp_q, fp_d;
  cmp_req_t    creq;
  cmp_rsp_t    crsp;

  alte_cmp u_cmp (.req_i(creq), .rsp_o(crsp));

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  logic [CW-1:0] ecap;
  logic          full;
  logic [PW-1:0] posx;
  always_comb begin
    ecap = (int'(cap_q) > DEPTH) ? CW'(DEPTH) : CW'(cap_q);
    full = cnt_q >= ecap;
    posx = PW'(pos_q);
  end

  assign creq.a = hold_q;
  assign creq.b = (st_q == S_STEP && (op_q == OP_SORTA || op_q == OP_SORTD))
                  ? rdata_q : val_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; k_d = k_q; lim_d = lim_q;
    ok_d = ok_q; rv_d = rv_q; fp_d = fp_q; hold_d = hold_q; swp_d = swp_q;
    we = 1'b0; waddr = AW'(k_q); wdata = val_q; raddr = AW'(k_q);
    unique case (st_q)
      S_IDLE: ;
      S_RD: begin
        // decode and validate
        ok_d = 1'b0; rv_d = '0; fp_d = '0; k_d = '0; st_d = S_DONE;
        case (op_q)
          OP_APPEND: if (!full) begin
            we = 1'b1; waddr = AW'(cnt_q); cnt_d = cnt_q + 1'b1; ok_d = 1'b1;
          end
          OP_INSERT: if (!full && posx >= 1 && posx <= PW'(cnt_q) + 1) begin
            ok_d = 1'b1; k_d = cnt_q; st_d = S_WAIT;
          end
          OP_REMOVE: if (posx >= 1 && posx <= PW'(cnt_q)) begin
            ok_d = 1'b1; k_d = CW'(pos_q - 7'd1); st_d = S_WAIT;
          end
          OP_GET, OP_SET: if (posx >= 1 && posx <= PW'(cnt_q)) begin
            ok_d = 1'b1;
            if (op_q == OP_SET) begin
              we = 1'b1; waddr = AW'(pos_q - 7'd1);
            end else begin
              raddr = AW'(pos_q - 7'd1); st_d = S_LAST;
            end
          end
          OP_SEARCH: begin ok_d = 1'b1; st_d = S_WAIT; end
          default: begin
            ok_d = 1'b1; lim_d = cnt_q; swp_d = 1'b0;
            st_d = (cnt_q < 2) ? S_DONE : S_WAIT;
          end
        endcase
      end
      S_WAIT: begin
        // issue the read of the entry to move or compare, or finish the command
        case (op_q)
          OP_INSERT: begin
            if (k_q == CW'(pos_q - 7'd1)) begin
              we = 1'b1; waddr = AW'(k_q); cnt_d = cnt_q + 1'b1; st_d = S_DONE;
            end else begin
              raddr = AW'(k_q - 1'b1); st_d = S_STEP;
            end
          end
          OP_REMOVE: begin
            if (k_q + 1'b1 >= cnt_q) begin
              cnt_d = cnt_q - 1'b1; st_d = S_DONE;
            end else begin
              raddr = AW'(k_q + 1'b1); st_d = S_STEP;
            end
          end
          OP_SEARCH: begin
            if (k_q >= cnt_q) st_d = S_DONE;
            else begin raddr = AW'(k_q); st_d = S_STEP; end
          end
          default: begin
            // sort: load element k into hold
            raddr = AW'(k_q); st_d = S_WR2;
          end
        endcase
      end
      S_WR2: begin
        hold_d = rdata_q; raddr = AW'(k_q + 1'b1); st_d = S_STEP;
      end
      S_STEP: begin
        case (op_q)
          OP_INSERT: begin
            we = 1'b1; waddr = AW'(k_q); wdata = rdata_q;
            k_d = k_q - 1'b1; st_d = S_WAIT;
          end
          OP_REMOVE: begin
            we = 1'b1; waddr = AW'(k_q); wdata = rdata_q;
            k_d = k_q + 1'b1; st_d = S_WAIT;
          end
          OP_SEARCH: begin
            if (rdata_q == val_q) begin
              fp_d = 7'(k_q + 1'b1); st_d = S_DONE;
            end else begin
              k_d = k_q + 1'b1; st_d = S_WAIT;
            end
          end
          default: begin
            // compare pair (k, k+1); swap via two writes
            if ((op_q == OP_SORTA) ? crsp.gt : crsp.lt) begin
              we = 1'b1; waddr = AW'(k_q); wdata = rdata_q; swp_d = 1'b1;
              st_d = S_LAST;
            end else begin
              hold_d = rdata_q; st_d = S_IDLE;
            end
            // advance handled below when not swapping
            if (st_d == S_IDLE) begin
              if (k_q + 2'd2 >= lim_q) begin
                k_d = '0; lim_d = lim_q - 1'b1;
                st_d = (lim_q <= 2) ? S_DONE : S_WAIT;
              end else begin
                k_d = k_q + 1'b1; raddr = AW'(k_q + 2'd2); st_d = S_STEP;
              end
            end
          end
        endcase
      end
      S_LAST: begin
        if (op_q == OP_GET) begin
          rv_d = rdata_q; st_d = S_DONE;
        end else begin
          // second half of swap: hold keeps the larger/smaller moved element
          we = 1'b1; waddr = AW'(k_q + 1'b1); wdata = hold_q;
          if (k_q + 2'd2 >= lim_q) begin
            k_d = '0; lim_d = lim_q - 1'b1;
            st_d = (lim_q <= 2) ? S_DONE : S_WAIT;
          end else begin
            k_d = k_q + 1'b1; raddr = AW'(k_q + 2'd2); st_d = S_STEP;
          end
        end
      end
      S_DONE: st_d = S_OUT;
      S_OUT: if (out_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cnt_q <= '0; cap_q <= 7'd64; ok_q <= 1'b0;
      k_q <= '0; lim_q <= '0; swp_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (st_q == S_IDLE && in_valid_i) st_q <= S_RD;
      else st_q <= st_d;
      cnt_q <= cnt_d; k_q <= k_d; lim_q <= lim_d; ok_q <= ok_d; swp_q <= swp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_IDLE && in_valid_i) begin
      op_q <= op_e'(operation_i); pos_q <= position_i; val_q <= value_i;
    end
    rv_q <= rv_d; fp_q <= fp_d; hold_q <= hold_d;
  end

  // In the sort, after writing k, the hold register must carry the moved value: on a swap hold
  // already holds entry k (the larger, or the smaller when descending), written at k+1.
  assign in_ready_o       = (st_q == S_IDLE);
  assign out_valid_o      = (st_q == S_OUT);
  assign ok_o             = ok_q;
  assign read_value_o     = rv_q;
  assign found_position_o = fp_q;
  assign list_length_o    = 7'(cnt_q);
  assign is_empty_o       = (cnt_q == '0);
  assign is_full_o        = full;

  `ALTE_ASSERT_IMP(a_len_bound, 1'b1, cnt_q <= CW'(DEPTH))
  `ALTE_ASSERT_IMP(a_rdy_out, out_valid_o, !in_ready_o)
  `ALTE_ASSERT_NEXT(a_hold_out, out_valid_o && !out_ready_i, out_valid_o && $stable(cnt_q))
endmodule
